// File: rtl/core/ptd_pkg.sv
// Shared widths, constants and item types of the point-to-triangle distance block.
// No dependencies; every other file of the block imports this package.
package ptd_pkg;

	localparam int FIELD_BITS  = 63;
	localparam int COORD_BITS  = 21;
	localparam int AXES        = 3;
	localparam int NUM_EDGES   = 3;
	localparam int DIFF_BITS   = COORD_BITS + 1;
	localparam int PROD_BITS   = 2 * DIFF_BITS;
	localparam int DOT_BITS    = PROD_BITS + 2;
	localparam int SQ_BITS     = 2 * DIFF_BITS;
	localparam int CROSS_BITS  = 2 * DIFF_BITS - 1;
	localparam int HALF_BITS   = (CROSS_BITS + 1) / 2;
	localparam int HIGH_BITS   = CROSS_BITS - HALF_BITS;
	localparam int CSQ_BITS    = 2 * CROSS_BITS;
	localparam int NUM_BITS    = CSQ_BITS + 2;
	localparam int DIST_BITS   = 23;
	localparam int ROOT_BITS   = (NUM_BITS > 2 * DIST_BITS + SQ_BITS) ?
		NUM_BITS : 2 * DIST_BITS + SQ_BITS;
	localparam int NPROD_BITS  = DIFF_BITS + COORD_BITS;
	localparam int PLANE_BITS  = NPROD_BITS + 2;
	localparam int NORM_FRAC   = COORD_BITS - 2;
	localparam int QPTR_BITS   = 2;
	localparam int QUEUE_DEPTH = 1 << QPTR_BITS;

	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;

	// One edge as the back end needs it.
	typedef struct packed {
		logic                             use_line;
		logic [SQ_BITS-1:0]               uu;
		logic [SQ_BITS-1:0]               ep;
		logic [AXES-1:0][CROSS_BITS-1:0]  cx;
	} edge_work_t;

	// One classified item between the front and the back end.
	typedef struct packed {
		logic                             all_within;
		logic                             degen;
		logic [DIST_BITS-1:0]             plane;
		edge_work_t [NUM_EDGES-1:0]       edges;
	} work_t;

	// Flags that ride along the back end next to the root stages.
	typedef struct packed {
		logic                             all_within;
		logic                             degen;
		logic [DIST_BITS-1:0]             plane;
	} flags_t;

	// Running state of one restoring root-of-ratio evaluation.
	typedef struct packed {
		logic [NUM_BITS-1:0]              num;
		logic [SQ_BITS-1:0]               den;
		logic [ROOT_BITS-1:0]             s;
		logic [ROOT_BITS-1:0]             dd;
		logic [DIST_BITS-1:0]             d;
	} root_t;

endpackage

// File: rtl/core/ptd_front.sv
// Front end: unpacks an item, forms differences, products and sums, classifies spans.
// Depends on ptd_pkg; feeds ptd_queue.
module ptd_front import ptd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FIELD_BITS-1:0] vertex_a,
	input  logic [FIELD_BITS-1:0] vertex_b,
	input  logic [FIELD_BITS-1:0] vertex_c,
	input  logic [FIELD_BITS-1:0] query_point,
	input  logic [FIELD_BITS-1:0] unit_normal,
	output logic                  work_valid,
	input  logic                  work_ready,
	output work_t                 work
);

	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [PROD_BITS:0]    cross_t;
	typedef logic signed [DOT_BITS-1:0]   dot_t;
	typedef logic signed [NPROD_BITS-1:0] nprod_t;

	// Edges are (A,B), (A,C), (B,C): first and second vertex of each.
	function automatic int edge_lo(input int e);
		return (e == 2) ? 1 : 0;
	endfunction

	function automatic int edge_hi(input int e);
		return (e == 0) ? 1 : 2;
	endfunction

	// Axis pair of one cross product component.
	function automatic int axis_next(input int i);
		return (i == 2) ? 0 : i + 1;
	endfunction

	function automatic int axis_prev(input int i);
		return (i == 0) ? 2 : i - 1;
	endfunction

	function automatic coord_t crd(input logic [FIELD_BITS-1:0] word, input int i);
		return coord_t'(word[i*COORD_BITS +: COORD_BITS]);
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	diff_t  pv_s1 [NUM_EDGES][AXES];
	diff_t  ue_s1 [NUM_EDGES][AXES];
	coord_t n_s1 [AXES];

	prod_t  m0_s2 [NUM_EDGES][AXES];
	prod_t  m1_s2 [NUM_EDGES][AXES];
	prod_t  mu_s2 [NUM_EDGES][AXES];
	prod_t  cp_s2 [NUM_EDGES][AXES];
	prod_t  cn_s2 [NUM_EDGES][AXES];
	prod_t  sq_s2 [NUM_EDGES][AXES];
	nprod_t np_s2 [AXES];

	dot_t                    d1_s3 [NUM_EDGES];
	dot_t                    d2_s3 [NUM_EDGES];
	logic [SQ_BITS-1:0]      uu_s3 [NUM_EDGES];
	cross_t                  cx_s3 [NUM_EDGES][AXES];
	logic [SQ_BITS-1:0]      vs_s3 [NUM_EDGES];
	logic signed [PLANE_BITS-1:0] pl_s3;

	work_t work_s4;

	logic [FIELD_BITS-1:0] vtx [NUM_EDGES];

	assign en         = !v_s4 || work_ready;
	assign in_ready   = en;
	assign work_valid = v_s4;
	assign work       = work_s4;

	always_comb begin
		vtx[0] = vertex_a;
		vtx[1] = vertex_b;
		vtx[2] = vertex_c;
	end

	// d2 is the stored sum itself, not its negation; P lies in the span when d1 >= 0 and d2 <= 0.
	function automatic work_t classify();
		work_t                   w;
		logic [NUM_EDGES-1:0]    in_span;
		logic [NUM_EDGES-1:0]    zero_len;
		logic [PLANE_BITS-1:0]   mag;
		logic [PLANE_BITS-NORM_FRAC-1:0] shifted;
		logic [PROD_BITS:0]      cm;
		w = '0;
		for (int e = 0; e < NUM_EDGES; e++) begin
			in_span[e]  = (d1_s3[e] == 0) || (d2_s3[e] == 0) || (d1_s3[e] > 0 && d2_s3[e] < 0);
			zero_len[e] = (uu_s3[e] == '0);
			w.edges[e].use_line = in_span[e] && !zero_len[e];
			w.edges[e].uu = uu_s3[e];
			w.edges[e].ep = (vs_s3[edge_lo(e)] < vs_s3[edge_hi(e)]) ?
				vs_s3[edge_lo(e)] : vs_s3[edge_hi(e)];
			for (int i = 0; i < AXES; i++) begin
				cm = cx_s3[e][i][PROD_BITS] ? unsigned'(-cx_s3[e][i]) : unsigned'(cx_s3[e][i]);
				w.edges[e].cx[i] = cm[CROSS_BITS-1:0];
			end
		end
		w.all_within = &in_span;
		w.degen      = |zero_len;
		mag     = pl_s3[PLANE_BITS-1] ? unsigned'(-pl_s3) : unsigned'(pl_s3);
		shifted = mag[PLANE_BITS-1:NORM_FRAC];
		w.plane = (|shifted[PLANE_BITS-NORM_FRAC-1:DIST_BITS]) ? DIST_MAX :
			shifted[DIST_BITS-1:0];
		return w;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Differences, products, sums, classification: one step per stage.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < AXES; i++) begin
				n_s1[i] <= crd(unit_normal, i);
				for (int v = 0; v < NUM_EDGES; v++)
					pv_s1[v][i] <= DIFF_BITS'(crd(query_point, i)) - DIFF_BITS'(crd(vtx[v], i));
				for (int e = 0; e < NUM_EDGES; e++)
					ue_s1[e][i] <= DIFF_BITS'(crd(vtx[edge_hi(e)], i)) -
						DIFF_BITS'(crd(vtx[edge_lo(e)], i));
			end

			for (int i = 0; i < AXES; i++) begin
				np_s2[i] <= NPROD_BITS'(pv_s1[0][i]) * NPROD_BITS'(n_s1[i]);
				for (int e = 0; e < NUM_EDGES; e++) begin
					m0_s2[e][i] <= PROD_BITS'(ue_s1[e][i]) * PROD_BITS'(pv_s1[edge_lo(e)][i]);
					m1_s2[e][i] <= PROD_BITS'(ue_s1[e][i]) * PROD_BITS'(pv_s1[edge_hi(e)][i]);
					mu_s2[e][i] <= PROD_BITS'(ue_s1[e][i]) * PROD_BITS'(ue_s1[e][i]);
					cp_s2[e][i] <= PROD_BITS'(ue_s1[e][axis_next(i)]) *
						PROD_BITS'(pv_s1[edge_lo(e)][axis_prev(i)]);
					cn_s2[e][i] <= PROD_BITS'(ue_s1[e][axis_prev(i)]) *
						PROD_BITS'(pv_s1[edge_lo(e)][axis_next(i)]);
					sq_s2[e][i] <= PROD_BITS'(pv_s1[e][i]) * PROD_BITS'(pv_s1[e][i]);
				end
			end

			pl_s3 <= PLANE_BITS'(np_s2[0]) + PLANE_BITS'(np_s2[1]) + PLANE_BITS'(np_s2[2]);
			for (int e = 0; e < NUM_EDGES; e++) begin
				d1_s3[e] <= DOT_BITS'(m0_s2[e][0]) + DOT_BITS'(m0_s2[e][1]) +
					DOT_BITS'(m0_s2[e][2]);
				d2_s3[e] <= DOT_BITS'(m1_s2[e][0]) + DOT_BITS'(m1_s2[e][1]) +
					DOT_BITS'(m1_s2[e][2]);
				uu_s3[e] <= unsigned'(mu_s2[e][0]) + unsigned'(mu_s2[e][1]) +
					unsigned'(mu_s2[e][2]);
				vs_s3[e] <= unsigned'(sq_s2[e][0]) + unsigned'(sq_s2[e][1]) +
					unsigned'(sq_s2[e][2]);
				for (int i = 0; i < AXES; i++)
					cx_s3[e][i] <= (PROD_BITS+1)'(cp_s2[e][i]) - (PROD_BITS+1)'(cn_s2[e][i]);
			end

			work_s4 <= classify();
		end
	end

endmodule

// File: rtl/core/ptd_queue.sv
// Short item queue that decouples the front end from the back end.
// Depends on ptd_pkg for the item type and depth.
module ptd_queue import ptd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  work_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output work_t pop_data
);

	work_t                entries_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 push, pop;

	assign push_ready = (count_q != (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_data;
	end

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow on push");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not shrink on pop");

endmodule

// File: rtl/core/ptd_back.sv
// Back end: squares the cross products, runs three root pipelines, takes the minimum.
// Depends on ptd_pkg; drains ptd_queue and drives the result channel.
module ptd_back import ptd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 work_valid,
	output logic                 work_ready,
	input  work_t                work,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DIST_BITS-1:0] distance,
	output logic                 edge_case,
	output logic                 degenerate_edge
);

	// Try one more result bit: T = (d + 2^b)^2 * den, built from running sums.
	function automatic root_t root_step(input root_t r, input int b);
		root_t                o;
		logic [ROOT_BITS-1:0] den_w;
		logic [ROOT_BITS-1:0] t;
		o     = r;
		den_w = ROOT_BITS'(r.den);
		t     = r.s + (r.dd << (b + 1)) + (den_w << (2 * b));
		if (t <= ROOT_BITS'(r.num)) begin
			o.s  = t;
			o.dd = r.dd + (den_w << b);
			o.d  = r.d | (DIST_BITS'(1) << b);
		end
		return o;
	endfunction

	logic en;
	logic v_s1, v_s2;
	logic v_rt [DIST_BITS+1];

	work_t w_s1, w_s2;
	logic [2*HIGH_BITS-1:0]         hh_s1 [NUM_EDGES][AXES];
	logic [HIGH_BITS+HALF_BITS-1:0] hl_s1 [NUM_EDGES][AXES];
	logic [2*HALF_BITS-1:0]         ll_s1 [NUM_EDGES][AXES];
	logic [CSQ_BITS-1:0]            sq_s2 [NUM_EDGES][AXES];

	root_t  rt_s [DIST_BITS+1][NUM_EDGES];
	flags_t fl_s [DIST_BITS+1];

	logic [DIST_BITS-1:0] distance_q;
	logic                 edge_case_q, degen_q, out_valid_q;
	logic [DIST_BITS-1:0] dmin;

	assign en              = !out_valid_q || out_ready;
	assign work_ready      = en;
	assign out_valid       = out_valid_q;
	assign distance        = distance_q;
	assign edge_case       = edge_case_q;
	assign degenerate_edge = degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int j = 0; j <= DIST_BITS; j++)
				v_rt[j] <= 1'b0;
		end else if (en) begin
			v_s1    <= work_valid;
			v_s2    <= v_s1;
			v_rt[0] <= v_s2;
			for (int j = 0; j < DIST_BITS; j++)
				v_rt[j+1] <= v_rt[j];
			out_valid_q <= v_rt[DIST_BITS];
		end
	end

	// Square each cross component in halves, then recombine.
	always_ff @(posedge clk) begin
		if (en) begin
			w_s1 <= work;
			w_s2 <= w_s1;
			for (int e = 0; e < NUM_EDGES; e++) begin
				for (int i = 0; i < AXES; i++) begin
					hh_s1[e][i] <= work.edges[e].cx[i][CROSS_BITS-1:HALF_BITS] *
						work.edges[e].cx[i][CROSS_BITS-1:HALF_BITS];
					hl_s1[e][i] <= work.edges[e].cx[i][CROSS_BITS-1:HALF_BITS] *
						work.edges[e].cx[i][HALF_BITS-1:0];
					ll_s1[e][i] <= work.edges[e].cx[i][HALF_BITS-1:0] *
						work.edges[e].cx[i][HALF_BITS-1:0];
					sq_s2[e][i] <= (CSQ_BITS'(hh_s1[e][i]) << (2 * HALF_BITS)) +
						(CSQ_BITS'(hl_s1[e][i]) << (HALF_BITS + 1)) + CSQ_BITS'(ll_s1[e][i]);
				end
			end
		end
	end

	// Load the root pipelines: line distance as cc/uu, else endpoint distance over one.
	always_ff @(posedge clk) begin
		if (en) begin
			fl_s[0].all_within <= w_s2.all_within;
			fl_s[0].degen      <= w_s2.degen;
			fl_s[0].plane      <= w_s2.plane;
			for (int e = 0; e < NUM_EDGES; e++) begin
				rt_s[0][e].num <= w_s2.edges[e].use_line ?
					NUM_BITS'(sq_s2[e][0]) + NUM_BITS'(sq_s2[e][1]) + NUM_BITS'(sq_s2[e][2]) :
					NUM_BITS'(w_s2.edges[e].ep);
				rt_s[0][e].den <= w_s2.edges[e].use_line ? w_s2.edges[e].uu : SQ_BITS'(1);
				rt_s[0][e].s   <= '0;
				rt_s[0][e].dd  <= '0;
				rt_s[0][e].d   <= '0;
			end
		end
	end

	for (genvar j = 0; j < DIST_BITS; j++) begin : g_root
		always_ff @(posedge clk) begin
			if (en) begin
				fl_s[j+1] <= fl_s[j];
				for (int e = 0; e < NUM_EDGES; e++)
					rt_s[j+1][e] <= root_step(rt_s[j][e], DIST_BITS - 1 - j);
			end
		end
	end

	always_comb begin
		dmin = (rt_s[DIST_BITS][0].d < rt_s[DIST_BITS][1].d) ?
			rt_s[DIST_BITS][0].d : rt_s[DIST_BITS][1].d;
		if (rt_s[DIST_BITS][2].d < dmin)
			dmin = rt_s[DIST_BITS][2].d;
	end

	// Plane case wins when P lies within every span; no edge flag then.
	always_ff @(posedge clk) begin
		if (en) begin
			distance_q  <= fl_s[DIST_BITS].all_within ? fl_s[DIST_BITS].plane : dmin;
			edge_case_q <= !fl_s[DIST_BITS].all_within;
			degen_q     <= !fl_s[DIST_BITS].all_within && fl_s[DIST_BITS].degen;
		end
	end

	a_plane_not_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !edge_case_q |-> !degen_q)
		else $error("degenerate flag set on a plane result");

	a_pop_enters: assert property (@(posedge clk) disable iff (!arst_n)
		en && work_valid |=> v_s1)
		else $error("popped item lost at back end entry");

endmodule

// File: rtl/core/point_triangle_distance.sv
// Top level of the point-to-triangle distance block.
// Depends on ptd_pkg, ptd_front, ptd_queue and ptd_back.
//
//  channel   handshake            payload
//  input     in_valid / in_ready  vertex_a, vertex_b, vertex_c, query_point, unit_normal
//  result    out_valid/out_ready  distance, edge_case, degenerate_edge
//
// One item per cycle sustained while out_ready stays high.
// The back end runs the 23 restoring root stages, one result bit each, per edge.
// Reset clears only valid bits, queue pointers and queue count; the block takes items right away.
// A stalled result stops the back end; the queue then fills and holds the front end.
module point_triangle_distance import ptd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FIELD_BITS-1:0] vertex_a,
	input  logic [FIELD_BITS-1:0] vertex_b,
	input  logic [FIELD_BITS-1:0] vertex_c,
	input  logic [FIELD_BITS-1:0] query_point,
	input  logic [FIELD_BITS-1:0] unit_normal,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DIST_BITS-1:0]  distance,
	output logic                  edge_case,
	output logic                  degenerate_edge
);

	// Classified items between the two halves.
	work_t f_work, b_work;
	logic  f_valid, f_ready, b_valid, b_ready;

	// Front: unpack, difference, dot and cross products, span classification.
	ptd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.vertex_a    (vertex_a),
		.vertex_b    (vertex_b),
		.vertex_c    (vertex_c),
		.query_point (query_point),
		.unit_normal (unit_normal),
		.work_valid  (f_valid),
		.work_ready  (f_ready),
		.work        (f_work)
	);

	// Hold a few items so each half can stall on its own.
	ptd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_work),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_work)
	);

	// Back: squared cross products, root pipelines, minimum and result register.
	ptd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.work_valid      (b_valid),
		.work_ready      (b_ready),
		.work            (b_work),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.distance        (distance),
		.edge_case       (edge_case),
		.degenerate_edge (degenerate_edge)
	);

endmodule
